FILE: design/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared widths and register indexes for the perspective projection pipeline.
// ----------------------------------------------------------------------------
package ppp_pkg;

    localparam int CRDW   = 21;  // Q13.8 coordinate
    localparam int DIFW   = 22;  // coordinate difference
    localparam int AXW    = 16;  // Q2.14 axis component
    localparam int PRODW  = 38;  // one axis term
    localparam int SUMW   = 40;  // dot product
    localparam int QW     = 32;  // Q16.16 result
    localparam int DIVSTG = 32;  // one quotient bit per stage
    localparam int CFGIW  = 3;

    typedef enum logic [CFGIW-1:0] {
        REG_MODE    = 3'd0,
        REG_CENTER  = 3'd1,
        REG_AXIS_U  = 3'd2,
        REG_AXIS_V  = 3'd3,
        REG_AXIS_N  = 3'd4,
        REG_SCALES  = 3'd5,
        REG_OFFSETS = 3'd6,
        REG_NONE    = 3'd7
    } t_cfg_idx;

    localparam logic signed [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] QMIN = {1'b1, {(QW-1){1'b0}}};

endpackage

FILE: design/ppp_dot.sv
// ----------------------------------------------------------------------------
// ppp_dot
// Three stages: centre subtraction, axis products, dot product sums.
// ----------------------------------------------------------------------------
module ppp_dot
    import ppp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [CRDW-1:0] i_px,
    input  logic signed [CRDW-1:0] i_py,
    input  logic signed [CRDW-1:0] i_pz,
    input  logic [3*CRDW-1:0]      i_center,
    input  logic [3*AXW-1:0]       i_axis_u,
    input  logic [3*AXW-1:0]       i_axis_v,
    input  logic [3*AXW-1:0]       i_axis_n,
    output logic signed [SUMW-1:0] o_pu,
    output logic signed [SUMW-1:0] o_pv,
    output logic signed [SUMW-1:0] o_pn
);

    logic signed [DIFW-1:0]  r_d    [3];
    logic signed [PRODW-1:0] r_prod [3][3];
    logic signed [SUMW-1:0]  r_sum  [3];
    logic signed [CRDW-1:0]  w_pt   [3];
    logic [3*AXW-1:0]        w_axis [3];

    assign w_pt[0]   = i_px;
    assign w_pt[1]   = i_py;
    assign w_pt[2]   = i_pz;
    assign w_axis[0] = i_axis_u;
    assign w_axis[1] = i_axis_v;
    assign w_axis[2] = i_axis_n;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_d[k] <= DIFW'(w_pt[k]) - DIFW'($signed(i_center[CRDW*k +: CRDW]));
            end
            for (int a = 0; a < 3; a++) begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[a][k] <= PRODW'(r_d[k] * $signed(w_axis[a][AXW*k +: AXW]));
                end
                r_sum[a] <= SUMW'(r_prod[a][0]) + SUMW'(r_prod[a][1])
                          + SUMW'(r_prod[a][2]);
            end
        end
    end

    assign o_pu = r_sum[0];
    assign o_pv = r_sum[1];
    assign o_pn = r_sum[2];

endmodule

FILE: design/ppp_div.sv
// ----------------------------------------------------------------------------
// ppp_div
// Pipelined restoring divider: (num * 2^16) / den, one quotient bit per
// stage, then a saturation stage that applies the sign.
// ----------------------------------------------------------------------------
module ppp_div
    import ppp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [SUMW-1:0]      i_num,
    input  logic [SUMW-1:0]      i_den,
    input  logic                 i_neg,
    output logic signed [QW-1:0] o_q
);

    logic [SUMW-1:0] r_rem [DIVSTG];
    logic [QW-1:0]   r_low [DIVSTG];
    logic [QW-1:0]   r_q   [DIVSTG];
    logic [SUMW-1:0] r_den [DIVSTG];
    logic            r_neg [DIVSTG];
    logic            r_ovf [DIVSTG];
    logic signed [QW-1:0] r_out;

    logic [SUMW-1:0] w_rem [DIVSTG];
    logic [QW-1:0]   w_low [DIVSTG];
    logic [QW-1:0]   w_q   [DIVSTG];
    logic [SUMW-1:0] w_den [DIVSTG];
    logic [SUMW:0]   w_t   [DIVSTG];
    logic            w_ge  [DIVSTG];
    logic [QW-1:0]   w_qf;

    // The quotient overflows 32 bits when the upper part of the shifted
    // numerator already reaches the divisor; a zero divisor always does.
    always_comb begin
        w_rem[0] = SUMW'(i_num[SUMW-1:16]);
        w_low[0] = {i_num[15:0], 16'd0};
        w_q[0]   = '0;
        w_den[0] = i_den;
        for (int k = 1; k < DIVSTG; k++) begin
            w_rem[k] = r_rem[k-1];
            w_low[k] = r_low[k-1];
            w_q[k]   = r_q[k-1];
            w_den[k] = r_den[k-1];
        end
        for (int k = 0; k < DIVSTG; k++) begin
            w_t[k]  = {w_rem[k], w_low[k][QW-1]};
            w_ge[k] = (w_t[k] >= {1'b0, w_den[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIVSTG; k++) begin
                r_rem[k] <= w_ge[k] ? SUMW'(w_t[k] - {1'b0, w_den[k]}) : w_t[k][SUMW-1:0];
                r_low[k] <= {w_low[k][QW-2:0], 1'b0};
                r_q[k]   <= {w_q[k][QW-2:0], w_ge[k]};
                r_den[k] <= w_den[k];
            end
            r_neg[0] <= i_neg;
            r_ovf[0] <= (SUMW'(i_num[SUMW-1:16]) >= i_den);
            for (int k = 1; k < DIVSTG; k++) begin
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
            r_out <= w_qf;
        end
    end

    always_comb begin
        if (r_neg[DIVSTG-1]) begin
            if (r_ovf[DIVSTG-1] || r_q[DIVSTG-1] > QW'(QMIN)) w_qf = QMIN;
            else                                           w_qf = QW'(0) - r_q[DIVSTG-1];
        end else begin
            if (r_ovf[DIVSTG-1] || r_q[DIVSTG-1][QW-1]) w_qf = QMAX;
            else                                      w_qf = r_q[DIVSTG-1];
        end
    end

    assign o_q = r_out;

endmodule

FILE: design/ppp_map.sv
// ----------------------------------------------------------------------------
// ppp_map
// Pixel mapping: registered scale product, then offset add, floor shift and
// saturation to Q16.16.
// ----------------------------------------------------------------------------
module ppp_map
    import ppp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [QW-1:0] i_vp,
    input  logic signed [QW-1:0] i_scale,
    input  logic signed [QW-1:0] i_offset,
    output logic signed [QW-1:0] o_pix
);

    logic signed [2*QW-1:0] r_prod;
    logic signed [2*QW:0]   w_acc;
    logic signed [2*QW-16:0] w_sh;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= (2*QW)'(i_scale) * (2*QW)'(i_vp);
        end
    end

    // The offset is moved up by 16 bits and sign extended before the add.
    always_comb begin
        w_acc = (2*QW+1)'(r_prod) + (2*QW+1)'($signed({i_offset, 16'd0}));
        w_sh  = w_acc[2*QW:16];
        if (w_sh > (2*QW-15)'(QMAX))      o_pix = QMAX;
        else if (w_sh < (2*QW-15)'(QMIN)) o_pix = QMIN;
        else                              o_pix = w_sh[QW-1:0];
    end

endmodule

FILE: design/perspective_point_to_pixel.sv
// ----------------------------------------------------------------------------
// perspective_point_to_pixel
// Fixed-point pinhole projection of world points to pixel coordinates, with
// a parallel projection mode.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Beat contents
// input     in         i_valid / o_ready         i_point_x, i_point_y, i_point_z
// output    out        o_valid / i_ready         o_pixel_col, o_pixel_row, o_zero_depth
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One beat is accepted per cycle while the output is not stalled, and every
// beat passes through three dot product stages, one sign and magnitude stage,
// 32 divider stages of one quotient bit each, a divider saturation stage, the
// pixel scale multiply and the output register; the divider sets the depth.
// All stages advance together whenever the output register is empty or
// being drained, so a stall freezes the pipe without losing or repeating a
// beat. Reset clears the valid bits and the configuration registers; the
// configuration port is always ready.
// ----------------------------------------------------------------------------
module perspective_point_to_pixel
    import ppp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [CRDW-1:0] i_point_x,
    input  logic signed [CRDW-1:0] i_point_y,
    input  logic signed [CRDW-1:0] i_point_z,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic signed [QW-1:0]   o_pixel_col,
    output logic signed [QW-1:0]   o_pixel_row,
    output logic                   o_zero_depth,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFGIW-1:0]       i_cfg_index,
    input  logic [63:0]            i_cfg_data
);

    localparam int LAT   = 39;
    // Side data is taken with the sign/magnitude stage and read at the
    // output register input.
    localparam int SIDEN = 35;

    typedef struct packed {
        logic                 zero;
        logic signed [QW-1:0] pcol;
        logic signed [QW-1:0] prow;
    } t_side;

    // Configuration registers.
    logic              r_mode;
    logic [3*CRDW-1:0] r_center;
    logic [3*AXW-1:0]  r_axis_u;
    logic [3*AXW-1:0]  r_axis_v;
    logic [3*AXW-1:0]  r_axis_n;
    logic [63:0]       r_scales;
    logic [63:0]       r_offsets;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_center  <= '0;
            r_axis_u  <= '0;
            r_axis_v  <= '0;
            r_axis_n  <= '0;
            r_scales  <= '0;
            r_offsets <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_MODE:    r_mode    <= i_cfg_data[0];
                REG_CENTER:  r_center  <= i_cfg_data[3*CRDW-1:0];
                REG_AXIS_U:  r_axis_u  <= i_cfg_data[3*AXW-1:0];
                REG_AXIS_V:  r_axis_v  <= i_cfg_data[3*AXW-1:0];
                REG_AXIS_N:  r_axis_n  <= i_cfg_data[3*AXW-1:0];
                REG_SCALES:  r_scales  <= i_cfg_data;
                REG_OFFSETS: r_offsets <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advance: everything moves when the output slot frees up.
    logic           w_en;
    logic [LAT-1:0] r_vld;

    assign w_en    = ~r_vld[LAT-1] | i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Dot products with the three view axes.
    logic signed [SUMW-1:0] w_pu, w_pv, w_pn;

    ppp_dot u_dot (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_px     (i_point_x),
        .i_py     (i_point_y),
        .i_pz     (i_point_z),
        .i_center (r_center),
        .i_axis_u (r_axis_u),
        .i_axis_v (r_axis_v),
        .i_axis_n (r_axis_n),
        .o_pu     (w_pu),
        .o_pv     (w_pv),
        .o_pn     (w_pn)
    );

    // Sign and magnitude stage for the dividers, plus the parallel results,
    // which are the products floored by 6 bits and saturated.
    logic [SUMW-1:0] r_mu, r_mv, r_mn;
    logic            r_nu, r_nv;
    t_side           r_side [SIDEN];
    t_side           w_side;
    logic signed [SUMW-7:0] w_fu, w_fv;

    always_comb begin
        w_fu = w_pu[SUMW-1:6];
        w_fv = w_pv[SUMW-1:6];
        w_side.zero = (w_pn == '0) & ~r_mode;
        if (w_fu > (SUMW-6)'(QMAX))      w_side.pcol = QMAX;
        else if (w_fu < (SUMW-6)'(QMIN)) w_side.pcol = QMIN;
        else                             w_side.pcol = w_fu[QW-1:0];
        if (w_fv > (SUMW-6)'(QMAX))      w_side.prow = QMAX;
        else if (w_fv < (SUMW-6)'(QMIN)) w_side.prow = QMIN;
        else                             w_side.prow = w_fv[QW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mu <= w_pu[SUMW-1] ? SUMW'(-w_pu) : SUMW'(w_pu);
            r_mv <= w_pv[SUMW-1] ? SUMW'(-w_pv) : SUMW'(w_pv);
            r_mn <= w_pn[SUMW-1] ? SUMW'(-w_pn) : SUMW'(w_pn);
            r_nu <= w_pu[SUMW-1] ^ w_pn[SUMW-1];
            r_nv <= w_pv[SUMW-1] ^ w_pn[SUMW-1];
            r_side[0] <= w_side;
            for (int k = 1; k < SIDEN; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Perspective quotients; a zero depth saturates by the numerator sign.
    logic signed [QW-1:0] w_vx, w_vy;

    ppp_div u_div_u (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_mu),
        .i_den (r_mn),
        .i_neg (r_nu),
        .o_q   (w_vx)
    );

    ppp_div u_div_v (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_mv),
        .i_den (r_mn),
        .i_neg (r_nv),
        .o_q   (w_vy)
    );

    // Column maps the V quotient, row maps the U quotient.
    logic signed [QW-1:0] w_col, w_row;

    ppp_map u_map_col (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_vp     (w_vy),
        .i_scale  (r_scales[63:32]),
        .i_offset (r_offsets[63:32]),
        .o_pix    (w_col)
    );

    ppp_map u_map_row (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_vp     (w_vx),
        .i_scale  (r_scales[31:0]),
        .i_offset (r_offsets[31:0]),
        .o_pix    (w_row)
    );

    // Output register: pick perspective or parallel results.
    logic signed [QW-1:0] r_col, r_row;
    logic                 r_zero;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_col  <= r_mode ? r_side[SIDEN-1].pcol : w_col;
            r_row  <= r_mode ? r_side[SIDEN-1].prow : w_row;
            r_zero <= r_side[SIDEN-1].zero;
        end
    end

    assign o_pixel_col  = r_col;
    assign o_pixel_row  = r_row;
    assign o_zero_depth = r_zero;

endmodule

FILE: tb/ppp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppp_checker
// Watches the point, pixel and configuration channels of the projection
// block, keeps its own copy of the registers, computes the expected pixel
// for every accepted point and compares it with each result beat.
// ----------------------------------------------------------------------------
module ppp_checker
    import ppp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_in_ready,
    input  logic signed [CRDW-1:0] i_point_x,
    input  logic signed [CRDW-1:0] i_point_y,
    input  logic signed [CRDW-1:0] i_point_z,
    input  logic                   i_out_valid,
    input  logic                   i_ready,
    input  logic signed [QW-1:0]   i_pixel_col,
    input  logic signed [QW-1:0]   i_pixel_row,
    input  logic                   i_zero_depth,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFGIW-1:0]       i_cfg_index,
    input  logic [63:0]            i_cfg_data,
    output int                     o_errors,
    output int                     o_pending,
    output int                     o_zero_hits
);

    typedef struct packed {
        logic signed [QW-1:0] col;
        logic signed [QW-1:0] row;
        logic                 zero_depth;
    } t_pixel;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    logic        mode_par;
    logic [62:0] center;
    logic [47:0] ax_u, ax_v, ax_n;
    logic [63:0] scales, offsets;

    t_pixel pixel_q[$];

    function automatic longint clamp32(longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    function automatic longint dot_axis(logic [47:0] ax, longint dx, longint dy, longint dz);
        logic signed [15:0] cx, cy, cz;
        longint s;
        cx = ax[15:0];
        cy = ax[31:16];
        cz = ax[47:32];
        s = cx * dx + cy * dy + cz * dz;
        return s;
    endfunction

    // Q16.16 quotient, truncated toward zero; the depth is never zero here.
    function automatic longint ratio_q16(longint num, longint den);
        longint q;
        q = (num * 65536) / den;
        return clamp32(q);
    endfunction

    function automatic longint to_pixel(logic [31:0] scale, longint vp, logic [31:0] offs);
        logic signed [31:0] sc, of;
        longint acc;
        sc = scale;
        of = offs;
        acc = sc * vp + of * 65536;
        return clamp32(acc >>> 16);
    endfunction

    function automatic t_pixel project_point(logic signed [CRDW-1:0] px,
                                             logic signed [CRDW-1:0] py,
                                             logic signed [CRDW-1:0] pz);
        logic signed [CRDW-1:0] c0, c1, c2;
        longint dx, dy, dz, pu, pv, pn, vx, vy;
        t_pixel r;
        c0 = center[20:0];
        c1 = center[41:21];
        c2 = center[62:42];
        dx = px;
        dy = py;
        dz = pz;
        dx = dx - c0;
        dy = dy - c1;
        dz = dz - c2;
        pu = dot_axis(ax_u, dx, dy, dz);
        pv = dot_axis(ax_v, dx, dy, dz);
        r.zero_depth = 1'b0;
        if (mode_par) begin
            r.col = QW'(clamp32(pu >>> 6));
            r.row = QW'(clamp32(pv >>> 6));
        end else begin
            pn = dot_axis(ax_n, dx, dy, dz);
            if (pn == 0) begin
                // Point in the camera plane: the quotients saturate by sign.
                r.zero_depth = 1'b1;
                vx = (pu < 0) ? S32_MIN : S32_MAX;
                vy = (pv < 0) ? S32_MIN : S32_MAX;
            end else begin
                vx = ratio_q16(pu, pn);
                vy = ratio_q16(pv, pn);
            end
            r.col = QW'(to_pixel(scales[63:32], vy, offsets[63:32]));
            r.row = QW'(to_pixel(scales[31:0], vx, offsets[31:0]));
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0d expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    assign o_pending = pixel_q.size();

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            mode_par <= 1'b0;
            center   <= '0;
            ax_u     <= '0;
            ax_v     <= '0;
            ax_n     <= '0;
            scales   <= '0;
            offsets  <= '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    REG_MODE:    mode_par <= i_cfg_data[0];
                    REG_CENTER:  center   <= i_cfg_data[62:0];
                    REG_AXIS_U:  ax_u     <= i_cfg_data[47:0];
                    REG_AXIS_V:  ax_v     <= i_cfg_data[47:0];
                    REG_AXIS_N:  ax_n     <= i_cfg_data[47:0];
                    REG_SCALES:  scales   <= i_cfg_data;
                    REG_OFFSETS: offsets  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && i_in_ready)
                pixel_q.push_back(project_point(i_point_x, i_point_y, i_point_z));
            if (i_out_valid && i_ready) begin
                if (pixel_q.size() == 0) begin
                    $display("[%0t] result beat with no point outstanding", $realtime);
                    o_errors++;
                end else begin
                    want = pixel_q.pop_front();
                    if (i_pixel_col !== want.col)
                        report_mismatch("pixel_col", i_pixel_col, want.col);
                    if (i_pixel_row !== want.row)
                        report_mismatch("pixel_row", i_pixel_row, want.row);
                    if (i_zero_depth !== want.zero_depth)
                        report_mismatch("zero_depth", i_zero_depth, want.zero_depth);
                    if (want.zero_depth)
                        o_zero_hits++;
                end
            end
        end
    end

    initial begin
        o_errors    = 0;
        o_zero_hits = 0;
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the perspective projection block: programs the
// camera registers between phases, streams points under varying back
// pressure and leaves all prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module tb;
    import ppp_pkg::*;

    // The pipe is 39 stages deep; after the last result we give it a margin.
    localparam int DRAIN_CYCLES = 60;
    // Cycles without any accepted beat on any channel before giving up.
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASES       = 9;
    localparam int PHASE_POINTS = 100;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic signed [CRDW-1:0] i_point_x = '0;
    logic signed [CRDW-1:0] i_point_y = '0;
    logic signed [CRDW-1:0] i_point_z = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic signed [QW-1:0]   o_pixel_col;
    logic signed [QW-1:0]   o_pixel_row;
    logic                   o_zero_depth;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFGIW-1:0]       i_cfg_index = '0;
    logic [63:0]            i_cfg_data = '0;

    int errors, pending, zero_hits;
    int send_idle_pct, recv_idle_pct;
    int points_sent;
    int quiet_cycles;

    always #1 i_clk = ~i_clk;

    perspective_point_to_pixel dut (.*);

    ppp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_in_ready   (o_ready),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_point_z    (i_point_z),
        .i_out_valid  (o_valid),
        .i_ready      (i_ready),
        .i_pixel_col  (o_pixel_col),
        .i_pixel_row  (o_pixel_row),
        .i_zero_depth (o_zero_depth),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_zero_hits  (zero_hits)
    );

    // The receiver drops ready at random in the share of cycles asked for.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: any accepted beat on any channel restarts the count.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", pending);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Waits for the edge at which the current beat is taken. Ready is read
    // at the falling edge, when every driver has settled for the cycle.
    task automatic wait_point_taken();
        logic taken;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_ready;
            @(posedge i_clk);
        end
    endtask

    // A point beat; valid stays high into the next beat unless a gap is drawn.
    task automatic send_point(logic signed [CRDW-1:0] x, logic signed [CRDW-1:0] y,
                              logic signed [CRDW-1:0] z);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct)
            gap = $urandom_range(6, 1);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_point_x <= x;
        i_point_y <= y;
        i_point_z <= z;
        wait_point_taken();
        points_sent++;
    endtask

    task automatic end_points();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Configuration beats are only written while the pipe is empty.
    task automatic write_reg(t_cfg_idx idx, logic [63:0] data);
        logic taken;
        taken = 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [47:0] pack_axis(int x, int y, int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    function automatic logic [62:0] pack_center(int x, int y, int z);
        return {21'(z), 21'(y), 21'(x)};
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // A full register set. Kind 0 is a plausible camera, 1 all bits set,
    // 2 the most negative values, 3 raw random bits.
    task automatic program_camera(int kind, logic par);
        int i;
        logic [63:0] v;
        write_reg(REG_MODE, {63'($urandom), par});
        for (i = REG_CENTER; i <= REG_OFFSETS; i++) begin
            case (kind)
                1: v = '1;
                2: begin
                    case (t_cfg_idx'(i))
                        REG_CENTER:               v = {1'b0, pack_center(-1048576, -1048576,
                                                                         -1048576)};
                        REG_SCALES, REG_OFFSETS:  v = {32'h8000_0000, 32'h8000_0000};
                        default:                  v = {16'h0, pack_axis(-32768, -32768, -32768)};
                    endcase
                end
                3: v = rand64();
                default: begin
                    case (t_cfg_idx'(i))
                        REG_CENTER:
                            v = {1'b0, pack_center($urandom_range(8192) - 4096,
                                                   $urandom_range(8192) - 4096,
                                                   $urandom_range(8192) - 4096)};
                        REG_SCALES:
                            v = {32'($urandom_range(1 << 22)), 32'($urandom_range(1 << 22))};
                        REG_OFFSETS:
                            v = {32'($urandom_range(640 << 16)), 32'($urandom_range(480 << 16))};
                        default:
                            v = {16'($urandom), pack_axis($urandom_range(32768) - 16384,
                                                          $urandom_range(32768) - 16384,
                                                          $urandom_range(32768) - 16384)};
                    endcase
                end
            endcase
            write_reg(t_cfg_idx'(i), v);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly points near the camera so that depth and quotients stay in range,
    // with some full-range noise and some small points with a zero z coordinate.
    task automatic send_random_point();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
            send_point(21'($urandom_range(16384) - 8192), 21'($urandom_range(16384) - 8192),
                       21'($urandom_range(16384) - 8192));
        else if (sel < 70)
            send_point(21'($urandom_range(64) - 32), 21'($urandom_range(64) - 32), 21'd0);
        else
            send_point(21'($urandom), 21'($urandom), 21'($urandom));
    endtask

    initial begin
        int p, k, kind;
        send_idle_pct = 12;
        recv_idle_pct = 50;
        points_sent   = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: an identity camera at the origin with 1.0 scales.
        write_reg(REG_MODE, 64'd0);
        write_reg(REG_CENTER, 64'd0);
        write_reg(REG_AXIS_U, {16'h0, pack_axis(16384, 0, 0)});
        write_reg(REG_AXIS_V, {16'h0, pack_axis(0, 16384, 0)});
        write_reg(REG_AXIS_N, {16'h0, pack_axis(0, 0, 16384)});
        write_reg(REG_SCALES, {32'h0001_0000, 32'h0001_0000});
        write_reg(REG_OFFSETS, {32'd320 << 16, 32'd240 << 16});
        // The unused index must leave every register alone.
        write_reg(REG_NONE, '1);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);

        send_point(256, 256, 256);
        send_point(-256, 512, 1024);
        send_point(21'sh0FFFFF, 21'sh0FFFFF, 21'sh0FFFFF);
        send_point(21'sh100000, 21'sh100000, 21'sh100000);
        send_point(21'sh0FFFFF, 21'sh100000, 1);
        send_point(21'sh100000, 21'sh0FFFFF, -1);
        // Zero depth with positive, negative and zero numerators, then a far and a near point.
        send_point(100, 200, 0);
        send_point(-100, -200, 0);
        send_point(0, 0, 0);
        send_point(-100, 0, 0);
        send_point(1, 1, 21'sh100000);
        send_point(0, 0, 1);
        end_points();
        wait_drained();

        // Parallel mode with the same axes, including the coordinate extremes.
        write_reg(REG_MODE, 64'd1);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        send_point(256, -256, 0);
        send_point(21'sh0FFFFF, 21'sh100000, 0);
        send_point(0, 0, 0);
        send_point(-1, -1, -1);
        end_points();
        wait_drained();

        for (p = 0; p < PHASES; p++) begin
            // Three phases each of slow receiver, slow sender, then full rate.
            send_idle_pct = (p < 3) ? 12 : (p < 6) ? 50 : 0;
            recv_idle_pct = (p < 3) ? 50 : (p < 6) ? 12 : 0;
            kind = (p == 1) ? 1 : (p == 2) ? 2 : (p % 3 == 0) ? 0 : $urandom_range(3);
            program_camera(kind, (p % 2 == 1));
            for (k = 0; k < PHASE_POINTS; k++) begin
                // Once in the run the sender holds off until the pipe is empty.
                if (p == 4 && k == PHASE_POINTS / 2) begin
                    i_valid <= 1'b0;
                    @(posedge i_clk);
                    wait (pending == 0);
                    @(posedge i_clk);
                end
                send_random_point();
            end
            end_points();
            wait_drained();
        end

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d points over %0d register phases in both projection modes,",
                 points_sent, PHASES + 2);
        $display("with %0d results on the camera plane and varied back pressure.", zero_hits);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
